FILE: rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the unique value stack
// Request and status codes, controller states and the result record.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		STAT_DONE     = 3'd0,
		STAT_DUP      = 3'd1,
		STAT_EMPTY    = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POP_RD,
		ST_POP_WB,
		ST_RESP
	} state_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] popped_value;
		logic [3:0]  found_position;
		logic [4:0]  entry_count;
	} res_t;

endpackage

FILE: rtl/uvs_mem.sv
// ----------------------------------------------------------------------------
// uvs_mem: entry store of the stack
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module uvs_mem #(
	parameter int unsigned DEPTH = uvs_pkg::STACK_DEPTH_DEF,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);
	import uvs_pkg::*;

	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/uvs_ctrl.sv
// ----------------------------------------------------------------------------
// uvs_ctrl: request sequencer of the stack
// Holds the fill count (reset by clear), scans the store from the top for push and
// search, reads back the top entry for pop and builds one result per request.
// ----------------------------------------------------------------------------
module uvs_ctrl #(
	parameter int unsigned DEPTH = uvs_pkg::STACK_DEPTH_DEF,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int unsigned FW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  uvs_pkg::req_kind_t req_kind,
	input  logic [31:0]      req_value,
	output logic             res_valid,
	input  logic             res_ready,
	output uvs_pkg::res_t    res,
	output logic [FW-1:0]    fill,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  logic [31:0]      rd_data,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [31:0]      wr_data
);
	import uvs_pkg::*;

	state_t        state_q, state_d;
	req_kind_t     kind_q;
	logic [31:0]   value_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] iss_q;
	logic          rd_vld_s1;
	logic [AW-1:0] pos_s1;
	status_t       status_q;
	logic [31:0]   popped_q;
	logic [AW-1:0] pos_q;

	logic issuing;
	logic hit;
	logic scan_end;
	logic is_full;

	assign is_full  = (fill_q == FW'(DEPTH));
	assign hit      = rd_vld_s1 && (rd_data == value_q);
	assign issuing  = (state_q == ST_SCAN) && (iss_q < fill_q) && !hit;
	assign scan_end = (state_q == ST_SCAN) && (hit || (!issuing && !rd_vld_s1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req_kind)
						REQ_PUSH, REQ_SEARCH: state_d = ST_SCAN;
						REQ_POP:              state_d = (fill_q == '0) ? ST_RESP : ST_POP_RD;
						REQ_CLEAR:            state_d = ST_RESP;
						default:              state_d = ST_RESP;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_RESP;
				end
			end
			ST_POP_RD: state_d = ST_POP_WB;
			ST_POP_WB: state_d = ST_RESP;
			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = AW'(fill_q - FW'(1) - iss_q);
		wr_en     = 1'b0;
		case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_SCAN: begin
				rd_en = issuing;
				wr_en = scan_end && (kind_q == REQ_PUSH) && !hit && !is_full;
			end
			ST_POP_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(fill_q - FW'(1));
			end
			ST_RESP: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign wr_addr = AW'(fill_q);
	assign wr_data = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			iss_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issuing;
			if (issuing) begin
				iss_q <= iss_q + FW'(1);
			end
			if (state_q == ST_IDLE && req_valid) begin
				iss_q <= '0;
				if (req_kind == REQ_CLEAR) begin
					fill_q <= '0;
				end
			end
			if (wr_en) begin
				fill_q <= fill_q + FW'(1);
			end
			if (state_q == ST_POP_WB) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	// payload of the request and the result
	always_ff @(posedge clk) begin
		pos_s1 <= iss_q[AW-1:0];
		if (state_q == ST_IDLE && req_valid) begin
			kind_q   <= req_kind;
			value_q  <= req_value;
			popped_q <= '0;
			pos_q    <= '0;
			status_q <= (req_kind == REQ_POP && fill_q == '0) ? STAT_EMPTY : STAT_DONE;
		end
		if (scan_end) begin
			if (kind_q == REQ_PUSH) begin
				if (hit) begin
					status_q <= STAT_DUP;
				end else if (is_full) begin
					status_q <= STAT_FULL;
				end else begin
					status_q <= STAT_DONE;
				end
			end else begin
				if (hit) begin
					status_q <= STAT_DONE;
					pos_q    <= pos_s1;
				end else begin
					status_q <= STAT_NOTFOUND;
				end
			end
		end
		if (state_q == ST_POP_WB) begin
			popped_q <= rd_data;
		end
	end

	assign res.status         = status_q;
	assign res.popped_value   = popped_q;
	assign res.found_position = 4'(pos_q);
	assign res.entry_count    = 5'(fill_q);
	assign fill               = fill_q;

endmodule

FILE: rtl/unique_value_stack_unit.sv
// ----------------------------------------------------------------------------
// unique_value_stack_unit: bounded LIFO of signed 32-bit values, no duplicates
// Push, pop, search and clear requests, one status result for each.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | value                          | req_type
//  m_axis   | out       | popped_value, found_position,  | status
//           |           | entry_count                    |
//
// Push and search scan the store from the top, one entry read per cycle
// through the single read port; a match ends the scan early. Pop reads the
// top entry and then lowers the fill count; pop on an empty stack and clear
// go straight to the result. The result register lets the next request
// enter while a result waits on m_tready. Reset empties the stack at once;
// the store itself is not cleared. A result stalled behind a full output
// register holds the sequencer until it moves.
// ----------------------------------------------------------------------------
module unique_value_stack_unit #(
	parameter int unsigned STACK_DEPTH = uvs_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] popped_value, [35:32] found_position,
	                               // [40:36] entry_count, [47:41] zero
	output logic [2:0]  m_tuser    // [2:0] status
);
	import uvs_pkg::*;

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic [FW-1:0] fill;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          out_vld_q;
	res_t          out_q;

	uvs_ctrl #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW),
		.FW    (FW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_kind  (req_kind_t'(s_tuser)),
		.req_value (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.fill      (fill),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	uvs_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// output register: load when empty or being drained
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {7'd0, out_q.entry_count, out_q.found_position, out_q.popped_value};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FW'(STACK_DEPTH))
		else $error("fill count beyond stack depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in progress");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_tvalid && !res_valid)
		else $error("result handed over but not presented");

	a_empty_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_EMPTY |-> m_tdata[31:0] == 32'd0)
		else $error("pop on empty stack returned a value");

endmodule

FILE: sim/unique_value_stack_unit_tb.sv
// ----------------------------------------------------------------------------
// unique_value_stack_unit_tb: self-checking bench for the unique value stack
// Drives push, pop, search and clear requests through the input stream,
// predicts every status result from a shadow copy of the stack and checks
// each output transaction field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module unique_value_stack_unit_tb;

	import uvs_pkg::*;

	localparam int DEPTH     = STACK_DEPTH_DEF;
	localparam int POOL_SIZE = 24;
	localparam int IDLE_PCT  = 27;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic [1:0]  s_tuser;   // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;   // [31:0] popped_value, [35:32] found_position,
	                        // [40:36] entry_count, [47:41] zero
	logic [2:0]  m_tuser;   // [2:0] status

	// shadow of the stack contents, entry 0 at the bottom
	logic [31:0] shadow_stack [DEPTH];
	int unsigned shadow_fill;
	logic [31:0] value_pool [POOL_SIZE];

	res_t        pending_results [$];
	bit          idle_on;
	int unsigned err_cnt;
	int unsigned results_seen;
	int unsigned kind_cnt [4];
	int unsigned status_cnt [5];

	unique_value_stack_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// position from the top of a stored value, or -1 when absent
	function automatic int locate_from_top(input logic [31:0] val);
		for (int k = 0; k < int'(shadow_fill); k++) begin
			if (shadow_stack[shadow_fill - 1 - k] == val)
				return k;
		end
		return -1;
	endfunction

	// apply one request to the shadow stack and return the status it earns
	function automatic res_t apply_request(input req_kind_t kind, input logic [31:0] val);
		res_t r;
		int   hit;
		r.status         = STAT_DONE;
		r.popped_value   = '0;
		r.found_position = '0;
		case (kind)
			REQ_PUSH: begin
				if (locate_from_top(val) >= 0)
					r.status = STAT_DUP;
				else if (shadow_fill >= DEPTH)
					r.status = STAT_FULL;
				else begin
					shadow_stack[shadow_fill] = val;
					shadow_fill++;
				end
			end
			REQ_POP: begin
				if (shadow_fill == 0)
					r.status = STAT_EMPTY;
				else begin
					shadow_fill--;
					r.popped_value = shadow_stack[shadow_fill];
				end
			end
			REQ_SEARCH: begin
				hit = locate_from_top(val);
				if (hit < 0)
					r.status = STAT_NOTFOUND;
				else
					r.found_position = 4'(hit);
			end
			default: begin
				shadow_fill = 0;
			end
		endcase
		r.entry_count = 5'(shadow_fill);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	// send one request; it is predicted at the edge that accepts it
	task automatic send_request(input req_kind_t kind, input logic [31:0] val);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = val;
		s_tuser  = kind;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(apply_request(kind, val));
		kind_cnt[kind]++;
	endtask

	task automatic release_input();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_for_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic req_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return REQ_PUSH;
		else if (r < 72)
			return REQ_POP;
		else if (r < 96)
			return REQ_SEARCH;
		return REQ_CLEAR;
	endfunction

	// favour stored and pooled values so duplicates and hits are common
	function automatic logic [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (shadow_fill != 0 && r < 30)
			return shadow_stack[$urandom_range(0, shadow_fill - 1)];
		else if (r < 70)
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic test_directed();
		send_request(REQ_POP, 32'h0);
		send_request(REQ_SEARCH, 32'h0);
		send_request(REQ_CLEAR, 32'hFFFF_FFFF);
		send_request(REQ_PUSH, 32'h8000_0000);
		send_request(REQ_PUSH, 32'h7FFF_FFFF);
		send_request(REQ_PUSH, 32'h0000_0000);
		send_request(REQ_PUSH, 32'hFFFF_FFFF);
		send_request(REQ_PUSH, 32'h7FFF_FFFF);
		send_request(REQ_SEARCH, 32'h8000_0000);
		// fill the remaining entries, so the stack is full
		for (int i = 0; i < DEPTH - 4; i++)
			send_request(REQ_PUSH, 32'h1000_0000 + 32'(i));
		send_request(REQ_PUSH, 32'h5A5A_A5A5);
		// a duplicate on a full stack still reports duplicate
		send_request(REQ_PUSH, 32'h0000_0000);
		send_request(REQ_SEARCH, 32'h8000_0000);
		send_request(REQ_POP, 32'h0);
		send_request(REQ_CLEAR, 32'h0);
		release_input();
	endtask

	task automatic test_random_traffic(input int n);
		for (int i = 0; i < n; i++)
			send_request(pick_kind(), pick_value());
		release_input();
	endtask

	task automatic test_back_to_back(input int n);
		idle_on = 1'b0;
		for (int i = 0; i < n; i++)
			send_request(pick_kind(), pick_value());
		release_input();
		idle_on = 1'b1;
	endtask

	// hold the sender until the block has drained, then carry on
	task automatic test_drain_pause(input int n);
		wait_for_results();
		repeat ($urandom_range(1, 6)) @(posedge clk);
		test_random_traffic(n);
	endtask

	always @(negedge clk)
		m_tready = idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending",
					64'({m_tuser, m_tdata}), 64'(0));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser < 5)
					status_cnt[m_tuser]++;
				if (m_tuser !== want.status)
					report_mismatch("status", 64'(m_tuser), 64'(want.status));
				if (m_tdata[31:0] !== want.popped_value)
					report_mismatch("popped_value", 64'(m_tdata[31:0]),
						64'(want.popped_value));
				if (m_tdata[35:32] !== want.found_position)
					report_mismatch("found_position", 64'(m_tdata[35:32]),
						64'(want.found_position));
				if (m_tdata[40:36] !== want.entry_count)
					report_mismatch("entry_count", 64'(m_tdata[40:36]),
						64'(want.entry_count));
				if (m_tdata[47:41] !== '0)
					report_mismatch("tdata padding", 64'(m_tdata[47:41]), 64'(0));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("unique_value_stack_unit verification failed");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = REQ_PUSH;
		idle_on      = 1'b1;
		err_cnt      = 0;
		results_seen = 0;
		shadow_fill  = 0;
		foreach (kind_cnt[i])   kind_cnt[i] = 0;
		foreach (status_cnt[i]) status_cnt[i] = 0;
		foreach (shadow_stack[i]) shadow_stack[i] = '0;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic(250);
		test_drain_pause(40);
		test_back_to_back(120);
		test_random_traffic(200);

		wait_for_results();
		repeat (40) @(posedge clk);

		$display("requests: %0d push, %0d pop, %0d search, %0d clear; %0d results checked",
			kind_cnt[REQ_PUSH], kind_cnt[REQ_POP], kind_cnt[REQ_SEARCH],
			kind_cnt[REQ_CLEAR], results_seen);
		$display("outcomes: %0d done, %0d duplicate, %0d empty, %0d full, %0d not found",
			status_cnt[STAT_DONE], status_cnt[STAT_DUP], status_cnt[STAT_EMPTY],
			status_cnt[STAT_FULL], status_cnt[STAT_NOTFOUND]);
		if (err_cnt == 0 && pending_results.size() == 0) begin
			$display("unique_value_stack_unit verification clean");
		end else begin
			$display("unique_value_stack_unit verification failed");
		end
		$finish;
	end

endmodule
